[sv/est_pkg.sv]
// est_pkg: shared types and constants of the event signature throttle
// holds the configuration register map, reset values and fixed field widths
// no dependencies
package est_pkg;

	// fixed widths of the item fields and the configuration port
	localparam int KEY_IN_BITS     = 32;
	localparam int TIME_IN_BITS    = 32;
	localparam int SLOT_INDEX_BITS = 6;
	localparam int CFG_INDEX_BITS  = 1;
	localparam int CFG_DATA_BITS   = 16;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_COOLDOWN_HIGH = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_COOLDOWN_LOW  = 1'b1;

	// register reset values
	localparam logic [CFG_DATA_BITS-1:0] COOLDOWN_HIGH_RESET = 16'd300;
	localparam logic [CFG_DATA_BITS-1:0] COOLDOWN_LOW_RESET  = 16'd900;

	// configuration handed to the controller
	typedef struct packed {
		logic [CFG_DATA_BITS-1:0] cooldown_high;
		logic [CFG_DATA_BITS-1:0] cooldown_low;
	} cfg_t;

endpackage

[sv/est_ram.sv]
// est_ram: simple dual port synchronous table memory, one write and one read a cycle
// read data registered
// depends on nothing
module est_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[sv/est_ctrl.sv]
// est_ctrl: scan sequencer of the event signature throttle
// walks the filled part of the table, decides emit, writes back time or a new entry
// depends on est_pkg; drives the est_ram ports
module est_ctrl
	import est_pkg::*;
#(
	parameter int ENTRIES = 64,
	parameter int KEY_BITS = 32,
	parameter int TIME_BITS = 32,
	localparam int IDX_BITS = $clog2(ENTRIES),
	localparam int CNT_BITS = $clog2(ENTRIES + 1),
	localparam int WORD_BITS = KEY_BITS + TIME_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       start,
	input  logic [KEY_IN_BITS-1:0]     event_key,
	input  logic                       urgent,
	input  logic [TIME_IN_BITS-1:0]    now_seconds,
	output logic                       busy,
	output logic                       done,
	output logic                       emit,
	output logic                       matched,
	output logic [SLOT_INDEX_BITS-1:0] slot_index,
	output logic                       wr_en,
	output logic [IDX_BITS-1:0]        wr_addr,
	output logic [WORD_BITS-1:0]       wr_data,
	output logic [IDX_BITS-1:0]        rd_addr,
	input  logic [WORD_BITS-1:0]       rd_data
);

	localparam int EXT_BITS = (IDX_BITS > SLOT_INDEX_BITS) ? IDX_BITS : SLOT_INDEX_BITS;
	localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(ENTRIES);
	localparam logic [IDX_BITS-1:0] LAST_SLOT  = IDX_BITS'(ENTRIES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MISS
	} state_t;

	state_t                  state_q;
	logic [CNT_BITS-1:0]     fill_q;
	logic [IDX_BITS-1:0]     ptr_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic                    look_s1;
	logic [IDX_BITS-1:0]     idx_s1;
	logic [KEY_BITS-1:0]     key_q;
	logic [TIME_BITS-1:0]    now_q;
	logic [CFG_DATA_BITS-1:0] cool_q;
	logic                    done_q;
	logic                    emit_q;
	logic                    matched_q;
	logic [IDX_BITS-1:0]     slot_q;

	logic [KEY_BITS-1:0]     rd_key;
	logic [TIME_BITS-1:0]    rd_time;
	logic [TIME_BITS-1:0]    diff;
	logic                    suppress;
	logic                    hit;
	logic                    last_look;
	logic                    full;
	logic [IDX_BITS-1:0]     miss_slot;
	logic [EXT_BITS-1:0]     slot_ext;

	// split the stored word and compare against the held item
	assign rd_key    = rd_data[WORD_BITS-1:TIME_BITS];
	assign rd_time   = rd_data[TIME_BITS-1:0];
	assign diff      = now_q - rd_time;
	assign suppress  = (rd_time != '0)
	                && (diff[TIME_BITS-1] || (diff < TIME_BITS'(cool_q)));
	assign hit       = (state_q == ST_SCAN) && look_s1 && (rd_key == key_q);
	assign last_look = look_s1 && (CNT_BITS'(idx_s1) == fill_q - CNT_BITS'(1));

	// victim slot on a miss: next free slot, or round-robin when full
	assign full      = (fill_q == FULL_COUNT);
	assign miss_slot = full ? ptr_q : fill_q[IDX_BITS-1:0];

	// memory ports
	assign rd_addr = cnt_q[IDX_BITS-1:0];
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = {key_q, now_q};
		if (hit && !suppress) begin
			wr_en = 1'b1;
		end
		if (state_q == ST_MISS) begin
			wr_en   = 1'b1;
			wr_addr = miss_slot;
		end
	end

	// outputs
	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign emit       = emit_q;
	assign matched    = matched_q;
	assign slot_ext   = EXT_BITS'(slot_q);
	assign slot_index = slot_ext[SLOT_INDEX_BITS-1:0];

	// sequencer, table occupancy and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			ptr_q     <= '0;
			cnt_q     <= '0;
			look_s1   <= 1'b0;
			done_q    <= 1'b0;
			emit_q    <= 1'b0;
			matched_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					look_s1 <= 1'b0;
					cnt_q   <= '0;
					if (start) begin
						key_q  <= KEY_BITS'(event_key);
						now_q  <= TIME_BITS'(now_seconds);
						cool_q <= urgent ? cfg.cooldown_high : cfg.cooldown_low;
						if (fill_q == '0) begin
							state_q <= ST_MISS;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// issue the next read while the previous one is compared
					look_s1 <= (cnt_q < fill_q);
					idx_s1  <= cnt_q[IDX_BITS-1:0];
					if (cnt_q < fill_q) begin
						cnt_q <= cnt_q + CNT_BITS'(1);
					end
					if (hit) begin
						done_q    <= 1'b1;
						emit_q    <= !suppress;
						matched_q <= 1'b1;
						slot_q    <= idx_s1;
						state_q   <= ST_IDLE;
					end else if (last_look) begin
						state_q <= ST_MISS;
					end
				end
				ST_MISS: begin
					done_q    <= 1'b1;
					emit_q    <= 1'b1;
					matched_q <= 1'b0;
					slot_q    <= miss_slot;
					if (full) begin
						ptr_q <= (ptr_q == LAST_SLOT) ? '0 : ptr_q + IDX_BITS'(1);
					end else begin
						fill_q <= fill_q + CNT_BITS'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/event_signature_throttle_top.sv]
// event_signature_throttle_top: per-key event rate limiter, top level
// a hit gives done once the scan reaches the matching slot; a miss gives done after
// the filled part of the table is scanned, or straight from the miss state with an empty table
// one item at a time: start is taken only while not busy; bound by the scan over the one table read port
// reset clears occupancy, pointer, sequencer state and result flags at once; no clearing pass is needed
// the receiver cannot stall: done is a one-cycle strobe
module event_signature_throttle_top
	import est_pkg::*;
#(
	parameter int ENTRIES = 64,
	parameter int KEY_BITS = 32,
	parameter int TIME_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]  cfg_addr,
	input  logic [CFG_DATA_BITS-1:0]   cfg_wdata,
	input  logic                       start,
	output logic                       busy,
	input  logic [KEY_IN_BITS-1:0]     event_key,
	input  logic                       urgent,
	input  logic [TIME_IN_BITS-1:0]    now_seconds,
	output logic                       done,
	output logic                       emit,
	output logic                       matched,
	output logic [SLOT_INDEX_BITS-1:0] slot_index
);

	localparam int IDX_BITS  = $clog2(ENTRIES);
	localparam int WORD_BITS = KEY_BITS + TIME_BITS;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [IDX_BITS-1:0]  wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [IDX_BITS-1:0]  rd_addr;
	logic [WORD_BITS-1:0] rd_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cooldown_high <= COOLDOWN_HIGH_RESET;
			cfg_q.cooldown_low  <= COOLDOWN_LOW_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_COOLDOWN_HIGH: cfg_q.cooldown_high <= cfg_wdata;
				CFG_COOLDOWN_LOW:  cfg_q.cooldown_low  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// scan sequencer
	est_ctrl #(
		.ENTRIES   (ENTRIES),
		.KEY_BITS  (KEY_BITS),
		.TIME_BITS (TIME_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.start         (start),
		.event_key     (event_key),
		.urgent        (urgent),
		.now_seconds   (now_seconds),
		.busy          (busy),
		.done          (done),
		.emit          (emit),
		.matched       (matched),
		.slot_index    (slot_index),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data)
	);

	// key and time table
	est_ram #(
		.DEPTH (ENTRIES),
		.WIDTH (WORD_BITS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// an accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// a result only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in flight");

	// a new entry is always emitted
	a_miss_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !matched) |-> emit)
		else $error("suppressed item on a table miss");

endmodule
